// ----- rtl/pwd_pkg.sv -----
// Package with shared types and constants for the path waypoint densifier.
package pwd_pkg;

  localparam int STEP_W = 23;
  localparam int POS_W  = 32;
  localparam int QUAT_W = 16;
  localparam int DIFF_W = 33;

  typedef struct packed {
    logic signed [QUAT_W-1:0] qw;
    logic signed [QUAT_W-1:0] qz;
    logic signed [QUAT_W-1:0] qy;
    logic signed [QUAT_W-1:0] qx;
  } quat_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQ    = 7'b0000010,
    ST_COUNT = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_WAIT  = 7'b0100000,
    ST_END   = 7'b1000000
  } state_t;

endpackage

// ----- rtl/path_waypoint_densifier.sv -----
// Top level of the path waypoint densifier: segment point count and linear interpolation.
//
//  channel  | dir | fields
//  s_axis   | in  | tdata: pos_x pos_y pos_z quat_x quat_y quat_z quat_w; tuser: final_waypoint
//  m_axis   | out | tdata: out_x out_y out_z out_qx out_qy out_qz out_qw; tlast: path_end
//  cfg      | in  | cfg_we, cfg_data: step_length
//
// A waypoint is accepted in the idle state, the horizontal length is squared over the x and y
// axes, and each candidate point count is then tried in turn on the shared multiplier. Each
// emitted point then takes, per axis, a magnitude step, a multiply by the point index and a
// bit-serial divide, and then loads the output register, which waits while a result is pending.
// A final waypoint is then emitted itself with tlast set, and a last step stores the waypoint before
// s_axis_tready rises again once the last result has been taken.
// Reset is synchronous and clears the stored waypoint and the step length to 1.0 m.
module path_waypoint_densifier #(
  parameter int MAX_STEPS = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
  input  logic [159:0] s_axis_tdata,
  // final_waypoint
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [pwd_pkg::STEP_W-1:0] cfg_data
);
  import pwd_pkg::*;

  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [STEP_W-1:0] STEP_MIN =
    STEP_W'((((64'd5) << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(64'd1 << FRAC_BITS);
  localparam int NUM_W = DIFF_W + CNT_W + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  state_t state;
  logic [STEP_W-1:0] step_length;
  logic have_previous;
  logic signed [POS_W-1:0] prev_pos [3];
  logic signed [POS_W-1:0] cur_pos [3];
  quat_t prev_q, cur_q;
  logic fin;
  logic signed [DIFF_W-1:0] delta [3];
  logic [64:0] len2;
  logic [CNT_W-1:0] steps, step_idx;
  logic [1:0] axis;
  logic [DIFF_W-1:0] mul_a, mul_b;
  logic [2*DIFF_W-1:0] mul_p;
  logic [DIFF_W-1:0] span;
  logic [NUM_W-1:0] rem, quo;
  logic [DCNT_W-1:0] dbit;
  logic [DIFF_W-1:0] mag;
  logic signed [POS_W-1:0] pt [3];
  logic [DIFF_W-1:0] ax, ay;
  logic [NUM_W:0] trial;

  assign ax = delta[0][DIFF_W-1] ? DIFF_W'(-delta[0]) : DIFF_W'(delta[0]);
  assign ay = delta[1][DIFF_W-1] ? DIFF_W'(-delta[1]) : DIFF_W'(delta[1]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = axis[0] ? ay : ax;
        mul_b = mul_a;
      end
      ST_COUNT: begin
        mul_a = span;
        mul_b = mul_a;
      end
      default: begin
        mul_a = mag;
        mul_b = DIFF_W'(step_idx);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign trial = {rem[NUM_W-1:0], quo[NUM_W-1]} - {1'b0, (NUM_W)'({steps, 1'b0})};

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step_length <= STEP_RST;
      have_previous <= 1'b0;
      m_axis_tvalid <= 1'b0;
      prev_q <= '0;
      for (int i = 0; i < 3; i++) prev_pos[i] <= '0;
    end else begin
      if (cfg_we) step_length <= (cfg_data < STEP_MIN) ? STEP_MIN : cfg_data;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            for (int i = 0; i < 3; i++) begin
              cur_pos[i] <= s_axis_tdata[32*i +: 32];
              delta[i] <= DIFF_W'($signed(s_axis_tdata[32*i +: 32]))
                          - DIFF_W'(prev_pos[i]);
            end
            cur_q <= s_axis_tdata[159:96];
            fin <= s_axis_tuser;
            axis <= '0;
            len2 <= '0;
            if (have_previous) state <= ST_SQ;
            else if (s_axis_tuser) state <= ST_END;
            else begin
              have_previous <= 1'b1;
              for (int i = 0; i < 3; i++) prev_pos[i] <= s_axis_tdata[32*i +: 32];
              prev_q <= s_axis_tdata[159:96];
            end
          end
        end
        ST_SQ: begin
          len2 <= len2 + 65'(mul_p[63:0]);
          axis <= axis + 2'd1;
          if (axis[0]) begin
            state <= ST_COUNT;
            step_idx <= CNT_W'(1);
            span <= DIFF_W'(step_length);
          end
        end
        ST_COUNT: begin
          if (!len2[64] && (mul_p[64:0] >= len2) || (32'(step_idx) == MAX_STEPS)) begin
            steps <= step_idx;
            step_idx <= '0;
            axis <= '0;
            state <= ST_DIV;
            dbit <= '0;
          end else begin
            step_idx <= step_idx + CNT_W'(1);
            span <= span + DIFF_W'(step_length);
          end
        end
        ST_DIV: begin
          if (dbit == '0) begin
            mag <= delta[axis][DIFF_W-1] ? DIFF_W'(-delta[axis]) : DIFF_W'(delta[axis]);
            dbit <= DCNT_W'(1);
          end else if (dbit == DCNT_W'(1)) begin
            quo <= NUM_W'({mul_p[NUM_W-2:0], 1'b0}) + NUM_W'(steps);
            rem <= '0;
            dbit <= DCNT_W'(2);
          end else begin
            if (!trial[NUM_W]) rem <= trial[NUM_W-1:0];
            else rem <= {rem[NUM_W-2:0], quo[NUM_W-1]};
            quo <= {quo[NUM_W-2:0], !trial[NUM_W]};
            if (dbit == DCNT_W'(NUM_W + 1)) begin
              dbit <= '0;
              if (axis == 2'd2) state <= ST_EMIT;
              else axis <= axis + 2'd1;
            end else dbit <= dbit + DCNT_W'(1);
          end
          if (dbit == DCNT_W'(NUM_W + 1)) begin
            pt[axis] <= prev_pos[axis] + (delta[axis][DIFF_W-1]
              ? -POS_W'({quo[NUM_W-2:0], !trial[NUM_W]})
              : POS_W'({quo[NUM_W-2:0], !trial[NUM_W]}));
          end
        end
        ST_EMIT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {((fin && step_idx == steps - CNT_W'(1)) ? cur_q : prev_q),
                             pt[2], pt[1], pt[0]};
            m_axis_tlast <= 1'b0;
            if (step_idx == steps - CNT_W'(1)) begin
              if (fin) state <= ST_END;
              else state <= ST_WAIT;
            end else begin
              step_idx <= step_idx + CNT_W'(1);
              axis <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_END: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {cur_q, cur_pos[2], cur_pos[1], cur_pos[0]};
            m_axis_tlast <= 1'b1;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          have_previous <= !fin;
          for (int i = 0; i < 3; i++) prev_pos[i] <= cur_pos[i];
          prev_q <= cur_q;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pwd_checker.sv -----
// Port checker for the path waypoint densifier, bound to the top level.
module pwd_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("ready straight after a final waypoint");
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("output valid after reset");
endmodule

bind path_waypoint_densifier pwd_checker u_pwd_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the path waypoint densifier, with a predicting scoreboard.
class densify_scoreboard;
  logic [pwd_pkg::STEP_W-1:0] step_len;
  bit                         have_prev;
  logic [31:0]                prev_x, prev_y, prev_z;
  logic [63:0]                prev_quat;
  logic [160:0]               expected_points[$];
  int                         mismatches;

  function new();
    step_len   = 23'd65536;
    have_prev  = 0;
    prev_x     = '0;
    prev_y     = '0;
    prev_z     = '0;
    prev_quat  = '0;
    mismatches = 0;
  endfunction

  function void write_step(logic [pwd_pkg::STEP_W-1:0] value);
    step_len = (value < 23'd3277) ? 23'd3277 : value;
  endfunction

  function int count_points(logic signed [32:0] dx, logic signed [32:0] dy);
    logic [65:0] ax, ay, total, span;
    ax = {33'd0, 33'(dx < 0 ? -dx : dx)};
    ay = {33'd0, 33'(dy < 0 ? -dy : dy)};
    total = ax * ax + ay * ay;
    if (total >= (66'd1 << 64)) return 63;
    for (int n = 1; n <= 63; n++) begin
      span = 66'(n) * 66'(step_len);
      if (span * span >= total) return n;
    end
    return 63;
  endfunction

  function logic [31:0] lerp_axis(logic [31:0] base, logic signed [32:0] d, int s, int steps);
    logic [65:0] mag, q;
    mag = {33'd0, 33'(d < 0 ? -d : d)} * 66'(s);
    q = (mag * 66'd2 + 66'(steps)) / (66'(steps) * 66'd2);
    return (d < 0) ? base - q[31:0] : base + q[31:0];
  endfunction

  // Predicts the dense points for one accepted waypoint.
  function void note_waypoint(logic [159:0] wp, logic fin);
    logic signed [32:0] dx, dy, dz;
    logic [63:0]        quat;
    int                 steps;
    logic [160:0]       item;
    quat = wp[159:96];
    if (have_prev) begin
      dx = 33'($signed(wp[31:0])) - 33'($signed(prev_x));
      dy = 33'($signed(wp[63:32])) - 33'($signed(prev_y));
      dz = 33'($signed(wp[95:64])) - 33'($signed(prev_z));
      steps = count_points(dx, dy);
      for (int s = 0; s < steps; s++) begin
        item = {1'b0,
          (fin && s == steps - 1) ? quat : prev_quat,
          lerp_axis(prev_z, dz, s, steps), lerp_axis(prev_y, dy, s, steps),
          lerp_axis(prev_x, dx, s, steps)};
        expected_points = {expected_points, item};
      end
    end
    if (fin) begin
      item = {1'b1, wp};
      expected_points = {expected_points, item};
    end
    have_prev = !fin;
    prev_x    = wp[31:0];
    prev_y    = wp[63:32];
    prev_z    = wp[95:64];
    prev_quat = quat;
  endfunction

  function void check_point(logic [159:0] data, logic last);
    logic [160:0] exp_pt;
    logic [31:0]  e, a;
    bit           bad;
    string        names[8];
    names = '{"out_x", "out_y", "out_z", "out_qx", "out_qy", "out_qz", "out_qw", "path_end"};
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected transaction: data=%h last=%b", data, last);
      return;
    end
    exp_pt = expected_points.pop_front();
    bad = 0;
    for (int f = 0; f < 8; f++) begin
      if (f < 3) begin
        e = exp_pt[f*32 +: 32];
        a = data[f*32 +: 32];
      end else if (f < 7) begin
        e = 32'(exp_pt[96 + (f-3)*16 +: 16]);
        a = 32'(data[96 + (f-3)*16 +: 16]);
      end else begin
        e = 32'(exp_pt[160]);
        a = 32'(last);
      end
      if (e !== a) begin
        bad = 1;
        if (mismatches < 10) $display("Mismatch on %s: expected %h, got %h", names[f], e, a);
      end
    end
    if (bad) mismatches++;
  endfunction
endclass

module tb_top;
  import pwd_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [159:0]       s_axis_tdata = '0;
  logic               s_axis_tuser = 0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [159:0]       m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_we = 0;
  logic [STEP_W-1:0]  cfg_data = '0;

  densify_scoreboard  sb;
  int                 idle_cycles = 0;
  int                 hold_request = 0;
  logic [31:0]        cur_x = 0, cur_y = 0;
  int                 wide_count = 0;

  path_waypoint_densifier dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_point(m_axis_tdata, m_axis_tlast);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        m_axis_tready <= 0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      gap = pick_gap();
      if (gap > 0 && $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(negedge clk);
    end
  end

  // Drives a waypoint; returns at the falling edge after acceptance or after a random gap.
  task automatic send_waypoint(logic [159:0] wp, logic fin, bit may_gap);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= wp;
    s_axis_tuser  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_waypoint(wp, fin);
    cur_x = wp[31:0];
    cur_y = wp[63:32];
    @(negedge clk);
    gap = may_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(negedge clk);
    while (sb.expected_points.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_step(logic [STEP_W-1:0] value);
    cfg_we   <= 1;
    cfg_data <= value;
    sb.write_step(value);
    @(negedge clk);
    cfg_we   <= 0;
  endtask

  function logic [31:0] near_coord(logic [31:0] base);
    int unsigned reach;
    int unsigned off;
    reach = $urandom_range(0, 6) * 32'(sb.step_len);
    off = $urandom_range(0, reach);
    return $urandom_range(0, 1) ? base + off : base - off;
  endfunction

  task automatic random_waypoint();
    logic [31:0] x, y, z;
    logic [63:0] quat;
    logic        fin;
    quat = {$urandom(), $urandom()};
    if (wide_count < 20 && $urandom_range(0, 99) < 4) begin
      wide_count++;
      x = $urandom();
      y = $urandom();
    end else if ($urandom_range(0, 9) == 0) begin
      x = cur_x;
      y = cur_y;
    end else begin
      x = near_coord(cur_x);
      y = near_coord(cur_y);
    end
    z = $urandom_range(0, 3) == 0 ? $urandom() : near_coord(cur_x);
    fin = $urandom_range(0, 99) < 15;
    send_waypoint({quat, z, y, x}, fin, 1);
  endtask

  initial begin
    logic [STEP_W-1:0] steps_list[5];
    sb = new();
    steps_list = '{23'd3277, 23'd1000, 23'h7FFFFF, 23'd6553600, 23'd0};
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: single-waypoint path, coincident points, vertical-only motion,
    // full-range extremes and saturated point count.
    send_waypoint({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 32'h7FFFFFFF, 32'h0, 32'h8000_0000},
                  1'b1, 0);
    send_waypoint({64'h0123_4567_89AB_CDEF, 32'h10000, 32'h20000, 32'h30000}, 1'b0, 0);
    send_waypoint({64'hFEDC_BA98_7654_3210, 32'h10000, 32'h20000, 32'h30000}, 1'b0, 0);
    send_waypoint({64'h8000_8000_8000_8000, 32'h7FFF_0000, 32'h20000, 32'h30000}, 1'b0, 1);
    send_waypoint({64'h7FFF_7FFF_7FFF_7FFF, 32'h8000_0000, 32'h2_8000, 32'h3_8000}, 1'b0, 1);
    send_waypoint({64'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, 0);
    send_waypoint({64'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, 0);
    send_waypoint({64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1, 0);
    send_waypoint({64'h0, 32'h0, 32'h4_8000, 32'hFFFC_0000}, 1'b0, 0);
    send_waypoint({64'h5555_AAAA_5555_AAAA, 32'h1234, 32'h3_8000, 32'hFFFF_8000}, 1'b1, 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) set_step(steps_list[phase-1]);
      for (int i = 0; i < 65; i++) begin
        if (i == 20) hold_request = 400;
        random_waypoint();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
  end
endmodule
